/* sv/load_adaptive_rate_governor_defines.svh */
// ---------------------------------------------------------------------------
// load adaptive rate governor assertion macros
// shared property wrappers for the port checker
// ---------------------------------------------------------------------------
`ifndef LOAD_ADAPTIVE_RATE_GOVERNOR_DEFINES_SVH
`define LOAD_ADAPTIVE_RATE_GOVERNOR_DEFINES_SVH

// clocked check, quiet while in reset
`define LARG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// clocked check that also holds during reset
`define LARG_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

/* sv/larg_pkg.sv */
// ---------------------------------------------------------------------------
// larg_pkg
// types, constants and ladder functions of the load adaptive rate governor
// ---------------------------------------------------------------------------
`default_nettype none

package larg_pkg;

  localparam logic [6:0] MaxRate = 7'd120;
  localparam int unsigned QDepth = 4;
  localparam int unsigned QIdxW = $clog2(QDepth);
  localparam int unsigned QCntW = $clog2(QDepth + 1);

  typedef enum logic [2:0] {
    CFG_ENABLE     = 3'd0,
    CFG_POOR_LIMIT = 3'd1,
    CFG_GOOD_LIMIT = 3'd2,
    CFG_LOWER_HOLD = 3'd3,
    CFG_RAISE_HOLD = 3'd4,
    CFG_LOSS_LIMIT = 3'd5,
    CFG_RTT_LIMIT  = 3'd6
  } cfg_idx_e;

  typedef enum logic [1:0] {
    KIND_DISABLED = 2'd0,
    KIND_BASELINE = 2'd1,
    KIND_EVAL     = 2'd2
  } kind_e;

  typedef struct packed {
    logic        enable;
    logic [7:0]  poor_limit;
    logic [7:0]  good_limit;
    logic [15:0] lower_hold_ms;
    logic [15:0] raise_hold_ms;
    logic [13:0] loss_limit;
    logic [15:0] rtt_limit_ms;
  } cfg_t;

  // per-sample facts carried from front to back
  typedef struct packed {
    kind_e       kind;
    logic        net_poor;
    logic [6:0]  top;
    logic [7:0]  eff;
    logic [47:0] now;
  } meta_t;

  typedef struct packed {
    meta_t meta;
    logic  high;
    logic  comfy;
  } item_t;

  typedef struct packed {
    logic [6:0] fps_cap;
    logic       cap_changed;
    kind_e      kind;
    logic       load_high;
  } result_t;

  function automatic logic [6:0] min7(input logic [6:0] a, input logic [6:0] b);
    return (a < b) ? a : b;
  endfunction

  function automatic logic [6:0] step_down(input logic [7:0] rate);
    logic [6:0] r;
    if (rate > 8'd90) r = 7'd90;
    else if (rate > 8'd60) r = 7'd60;
    else if (rate > 8'd45) r = 7'd45;
    else if (rate > 8'd30) r = 7'd30;
    else if (rate > 8'd20) r = 7'd20;
    else if (rate > 8'd15) r = 7'd15;
    else r = 7'd10;
    return r;
  endfunction

  function automatic logic [6:0] step_up(input logic [6:0] cap, input logic [6:0] top);
    logic [6:0] r;
    if (cap == 7'd0) r = 7'd0;
    else if (cap < 7'd15) r = min7(7'd15, top);
    else if (cap < 7'd20) r = min7(7'd20, top);
    else if (cap < 7'd30) r = min7(7'd30, top);
    else if (cap < 7'd45) r = min7(7'd45, top);
    else if (cap < 7'd60) r = min7(7'd60, top);
    else if (cap < 7'd90) r = min7(7'd90, top);
    else if (cap < top) r = top;
    else r = 7'd0;
    return r;
  endfunction

endpackage

`default_nettype wire

/* sv/larg_front.sv */
// ---------------------------------------------------------------------------
// larg_front
// sample intake: baseline check, tick deltas, busy share and load class
// ---------------------------------------------------------------------------
`default_nettype none

module larg_front (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire larg_pkg::cfg_t             cfg_i,
  input  wire logic                       push_i,
  output logic                            full_o,
  input  wire logic [63:0]                idle_ticks_i,
  input  wire logic [63:0]                total_ticks_i,
  input  wire logic [7:0]                 pipeline_fps_limit_i,
  input  wire logic [7:0]                 effective_fps_i,
  input  wire logic                       bandwidth_limited_i,
  input  wire logic                       loss_present_i,
  input  wire logic [13:0]                loss_level_i,
  input  wire logic                       rtt_present_i,
  input  wire logic [15:0]                rtt_ms_i,
  input  wire logic [47:0]                now_ms_i,
  input  wire logic [larg_pkg::QCntW-1:0] q_level_i,
  output logic                            q_push_o,
  output larg_pkg::item_t                 q_item_o
);
  import larg_pkg::*;

  logic        accept;
  logic        baseline;
  meta_t       a_meta_d, a_meta_q, b_meta_q;
  logic        a_valid_q, b_valid_q;
  logic [63:0] prev_idle_q, prev_total_q;
  logic [63:0] a_id_q, a_td_q;
  logic [63:0] busy_d, b_busy_q, b_td_q;
  logic [QCntW-1:0] level;
  logic [64:0] twice_busy, td_ext;
  logic [66:0] five_busy, twice_td;

  // credits: queue contents plus samples still in flight
  assign level = q_level_i + QCntW'(a_valid_q) + QCntW'(b_valid_q);
  assign full_o = (level >= QCntW'(QDepth));
  assign accept = push_i && !full_o;

  assign baseline = (prev_total_q == 64'd0) || (total_ticks_i <= prev_total_q) ||
                    (idle_ticks_i < prev_idle_q);

  always_comb begin
    a_meta_d.kind = !cfg_i.enable ? KIND_DISABLED : (baseline ? KIND_BASELINE : KIND_EVAL);
    a_meta_d.net_poor = bandwidth_limited_i ||
                        (loss_present_i && (loss_level_i >= cfg_i.loss_limit)) ||
                        (rtt_present_i && (rtt_ms_i >= cfg_i.rtt_limit_ms));
    if (pipeline_fps_limit_i == 8'd0) begin
      a_meta_d.top = 7'd1;
    end else if (pipeline_fps_limit_i > {1'b0, MaxRate}) begin
      a_meta_d.top = MaxRate;
    end else begin
      a_meta_d.top = pipeline_fps_limit_i[6:0];
    end
    a_meta_d.eff = effective_fps_i;
    a_meta_d.now = now_ms_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_idle_q  <= '0;
      prev_total_q <= '0;
      a_valid_q    <= 1'b0;
      b_valid_q    <= 1'b0;
    end else begin
      if (accept && cfg_i.enable) begin
        prev_idle_q  <= idle_ticks_i;
        prev_total_q <= total_ticks_i;
      end
      a_valid_q <= accept;
      b_valid_q <= a_valid_q;
    end
  end

  // stage a: deltas against the stored counters
  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_meta_q <= a_meta_d;
      a_id_q   <= idle_ticks_i - prev_idle_q;
      a_td_q   <= total_ticks_i - prev_total_q;
    end
  end

  // stage b: busy ticks, idle above total counts as no busy time
  assign busy_d = (a_id_q < a_td_q) ? (a_td_q - a_id_q) : 64'd0;

  always_ff @(posedge clk_i) begin
    if (a_valid_q) begin
      b_meta_q <= a_meta_q;
      b_busy_q <= busy_d;
      b_td_q   <= a_td_q;
    end
  end

  assign twice_busy = {b_busy_q, 1'b0};
  assign td_ext     = {1'b0, b_td_q};
  assign five_busy  = {1'b0, b_busy_q, 2'b00} + {3'b000, b_busy_q};
  assign twice_td   = {2'b00, b_td_q, 1'b0};

  always_comb begin
    q_push_o        = b_valid_q;
    q_item_o.meta   = b_meta_q;
    q_item_o.high   = (twice_busy >= td_ext);
    q_item_o.comfy  = (five_busy < twice_td);
  end

endmodule

`default_nettype wire

/* sv/larg_queue.sv */
// ---------------------------------------------------------------------------
// larg_queue
// short queue of classified samples between front and back
// ---------------------------------------------------------------------------
`default_nettype none

module larg_queue (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       push_i,
  input  wire larg_pkg::item_t            item_i,
  input  wire logic                       pop_i,
  output larg_pkg::item_t                 item_o,
  output logic                            empty_o,
  output logic [larg_pkg::QCntW-1:0]      level_o
);
  import larg_pkg::*;

  item_t             mem_q [QDepth];
  logic [QIdxW-1:0]  wptr_q, rptr_q;
  logic [QCntW-1:0]  cnt_q, cnt_d;
  logic              do_pop;

  assign empty_o = (cnt_q == '0);
  assign level_o = cnt_q;
  assign item_o  = mem_q[rptr_q];
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !do_pop) begin
      cnt_d = cnt_q + QCntW'(1);
    end else if (!push_i && do_pop) begin
      cnt_d = cnt_q - QCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= wptr_q + QIdxW'(1);
      end
      if (do_pop) begin
        rptr_q <= rptr_q + QIdxW'(1);
      end
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= item_i;
    end
  end

endmodule

`default_nettype wire

/* sv/larg_back.sv */
// ---------------------------------------------------------------------------
// larg_back
// governor: scores, cap ladder, change hold and the result buffer
// ---------------------------------------------------------------------------
`default_nettype none

module larg_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire larg_pkg::cfg_t  cfg_i,
  input  wire logic            q_empty_i,
  input  wire larg_pkg::item_t q_item_i,
  output logic                 q_pop_o,
  input  wire logic            pop_i,
  output logic                 empty_o,
  output larg_pkg::result_t    res_o
);
  import larg_pkg::*;

  logic [7:0]  poor_q, good_q, poor_d, good_d;
  logic [6:0]  cap_q, cap_d;
  logic [47:0] last_q, last_d;
  logic [7:0]  pc_n, gc_n;
  logic [6:0]  next_raw, next_cap;
  logic [48:0] since;
  logic        lower_wait, raise_wait, lowering, blocked, do_change, is_eval;
  result_t     res_d;
  result_t     buf_q [2];
  logic        wptr_q, rptr_q;
  logic [1:0]  cnt_q, cnt_d;
  logic        out_pop;

  assign out_pop = pop_i && (cnt_q != 2'd0);
  assign q_pop_o = !q_empty_i && (cnt_q != 2'd2);
  assign is_eval = (q_item_i.meta.kind == KIND_EVAL);

  // score update and ladder step
  always_comb begin
    pc_n     = poor_q;
    gc_n     = good_q;
    next_raw = cap_q;
    if (q_item_i.high) begin
      pc_n = (poor_q != 8'hFF) ? poor_q + 8'd1 : poor_q;
      gc_n = 8'd0;
      if (pc_n >= cfg_i.poor_limit) begin
        next_raw = step_down(q_item_i.meta.eff);
      end
    end else if (q_item_i.comfy && !q_item_i.meta.net_poor) begin
      pc_n = (poor_q != 8'd0) ? poor_q - 8'd1 : poor_q;
      gc_n = (good_q != 8'hFF) ? good_q + 8'd1 : good_q;
      if (gc_n >= cfg_i.good_limit) begin
        next_raw = step_up(cap_q, q_item_i.meta.top);
      end
    end else begin
      pc_n = (poor_q != 8'd0) ? poor_q - 8'd1 : poor_q;
      gc_n = (good_q != 8'd0) ? good_q - 8'd1 : good_q;
    end
  end

  // a cap at or above the top rate means uncapped
  assign next_cap = (next_raw >= q_item_i.meta.top) ? 7'd0 : next_raw;

  assign since      = {1'b0, q_item_i.meta.now} - {1'b0, last_q};
  assign lower_wait = since[48] || (since[47:0] < {32'd0, cfg_i.lower_hold_ms});
  assign raise_wait = since[48] || (since[47:0] < {32'd0, cfg_i.raise_hold_ms});
  assign lowering   = (next_cap != 7'd0) && ((cap_q == 7'd0) || (next_cap < cap_q));
  assign blocked    = (last_q != 48'd0) && (lowering ? lower_wait : raise_wait);
  assign do_change  = is_eval && (next_cap != cap_q) && !blocked;

  always_comb begin
    poor_d = poor_q;
    good_d = good_q;
    cap_d  = cap_q;
    last_d = last_q;
    if (q_pop_o && is_eval) begin
      if (do_change) begin
        poor_d = 8'd0;
        good_d = 8'd0;
        cap_d  = next_cap;
        last_d = q_item_i.meta.now;
      end else begin
        poor_d = pc_n;
        good_d = gc_n;
      end
    end
  end

  always_comb begin
    res_d.fps_cap     = do_change ? next_cap : cap_q;
    res_d.cap_changed = do_change;
    res_d.kind        = q_item_i.meta.kind;
    res_d.load_high   = is_eval && q_item_i.high;
  end

  always_comb begin
    cnt_d = cnt_q;
    if (q_pop_o && !out_pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!q_pop_o && out_pop) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poor_q <= '0;
      good_q <= '0;
      cap_q  <= '0;
      last_q <= '0;
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      poor_q <= poor_d;
      good_q <= good_d;
      cap_q  <= cap_d;
      last_q <= last_d;
      if (q_pop_o) begin
        wptr_q <= !wptr_q;
      end
      if (out_pop) begin
        rptr_q <= !rptr_q;
      end
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      buf_q[wptr_q] <= res_d;
    end
  end

  assign empty_o = (cnt_q == 2'd0);
  assign res_o   = buf_q[rptr_q];

endmodule

`default_nettype wire

/* sv/load_adaptive_rate_governor.sv */
// ---------------------------------------------------------------------------
// load_adaptive_rate_governor
// frame-rate cap governor driven by processor load and network health
// ---------------------------------------------------------------------------
// path: a sample passes stage a, stage b, the queue and the result buffer before its result shows
// throughput: one sample per cycle while full_o is low, set by the two front stages and a four-deep queue
// reset: config returns to defaults, counters, scores and cap clear, all queues empty
// no clearing pass after reset
`default_nettype none

module load_adaptive_rate_governor (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_addr_i,
  input  wire logic [15:0] cfg_wdata_i,
  input  wire logic        push_i,
  output logic             full_o,
  input  wire logic [63:0] idle_ticks_i,
  input  wire logic [63:0] total_ticks_i,
  input  wire logic [7:0]  pipeline_fps_limit_i,
  input  wire logic [7:0]  effective_fps_i,
  input  wire logic        bandwidth_limited_i,
  input  wire logic        loss_present_i,
  input  wire logic [13:0] loss_level_i,
  input  wire logic        rtt_present_i,
  input  wire logic [15:0] rtt_ms_i,
  input  wire logic [47:0] now_ms_i,
  output logic             empty_o,
  input  wire logic        pop_i,
  output logic [6:0]       fps_cap_o,
  output logic             cap_changed_o,
  output logic [1:0]       sample_kind_o,
  output logic             load_high_o
);
  import larg_pkg::*;

  cfg_t             cfg_q;
  logic             q_push, q_pop, q_empty;
  item_t            q_in, q_out;
  logic [QCntW-1:0] q_level;
  result_t          res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enable        <= 1'b1;
      cfg_q.poor_limit    <= 8'd3;
      cfg_q.good_limit    <= 8'd8;
      cfg_q.lower_hold_ms <= 16'd5000;
      cfg_q.raise_hold_ms <= 16'd15000;
      cfg_q.loss_limit    <= 14'd300;
      cfg_q.rtt_limit_ms  <= 16'd350;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CFG_ENABLE:     cfg_q.enable        <= cfg_wdata_i[0];
        CFG_POOR_LIMIT: cfg_q.poor_limit    <= cfg_wdata_i[7:0];
        CFG_GOOD_LIMIT: cfg_q.good_limit    <= cfg_wdata_i[7:0];
        CFG_LOWER_HOLD: cfg_q.lower_hold_ms <= cfg_wdata_i;
        CFG_RAISE_HOLD: cfg_q.raise_hold_ms <= cfg_wdata_i;
        CFG_LOSS_LIMIT: cfg_q.loss_limit    <= cfg_wdata_i[13:0];
        CFG_RTT_LIMIT:  cfg_q.rtt_limit_ms  <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  larg_front u_front (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_i                (cfg_q),
    .push_i               (push_i),
    .full_o               (full_o),
    .idle_ticks_i         (idle_ticks_i),
    .total_ticks_i        (total_ticks_i),
    .pipeline_fps_limit_i (pipeline_fps_limit_i),
    .effective_fps_i      (effective_fps_i),
    .bandwidth_limited_i  (bandwidth_limited_i),
    .loss_present_i       (loss_present_i),
    .loss_level_i         (loss_level_i),
    .rtt_present_i        (rtt_present_i),
    .rtt_ms_i             (rtt_ms_i),
    .now_ms_i             (now_ms_i),
    .q_level_i            (q_level),
    .q_push_o             (q_push),
    .q_item_o             (q_in)
  );

  larg_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (q_in),
    .pop_i   (q_pop),
    .item_o  (q_out),
    .empty_o (q_empty),
    .level_o (q_level)
  );

  larg_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .q_empty_i (q_empty),
    .q_item_i  (q_out),
    .q_pop_o   (q_pop),
    .pop_i     (pop_i),
    .empty_o   (empty_o),
    .res_o     (res)
  );

  assign fps_cap_o     = res.fps_cap;
  assign cap_changed_o = res.cap_changed;
  assign sample_kind_o = res.kind;
  assign load_high_o   = res.load_high;

endmodule

`default_nettype wire

/* sv/larg_checker.sv */
// ---------------------------------------------------------------------------
// larg_checker
// port-level checks of the rate governor, bound to the top level
// ---------------------------------------------------------------------------
`default_nettype none

`include "load_adaptive_rate_governor_defines.svh"

module larg_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        empty_o,
  input wire logic        pop_i,
  input wire logic [6:0]  fps_cap_o,
  input wire logic        cap_changed_o,
  input wire logic [1:0]  sample_kind_o,
  input wire logic        load_high_o
);
  import larg_pkg::*;

  // cap never exceeds the top rate
  property p_cap_range;
    !empty_o |-> (fps_cap_o <= MaxRate);
  endproperty

  // only evaluated samples may change the cap or flag high load
  property p_kind_flags;
    (!empty_o && (sample_kind_o != KIND_EVAL)) |-> (!cap_changed_o && !load_high_o);
  endproperty

  // result buffer is empty as reset lifts
  property p_reset_empty;
    $rose(rst_ni) |-> empty_o;
  endproperty

  // a waiting result stays put until taken
  property p_result_hold;
    (!empty_o && !pop_i) |=> (!empty_o && $stable(fps_cap_o) && $stable(sample_kind_o));
  endproperty

  `LARG_ASSERT(a_cap_range, p_cap_range, "cap above top rate")
  `LARG_ASSERT(a_kind_flags, p_kind_flags, "flags set on a word that was not evaluated")
  `LARG_ASSERT_RST(a_reset_empty, p_reset_empty, "results present as reset lifts")
  `LARG_ASSERT(a_result_hold, p_result_hold, "waiting result changed")

endmodule

bind load_adaptive_rate_governor larg_checker u_larg_checker (.*);

`default_nettype wire

/* tb/load_adaptive_rate_governor_checker.sv */
// ---------------------------------------------------------------------------
// load adaptive rate governor checker
// watches the sample and result channels and the register port, keeps its own
// copy of the governor state, predicts one result word per accepted sample
// and compares every popped word field by field with the oldest prediction
// ---------------------------------------------------------------------------
module load_adaptive_rate_governor_checker import larg_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_addr_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        push_i,
  input  logic        full_i,
  input  logic [63:0] idle_ticks_i,
  input  logic [63:0] total_ticks_i,
  input  logic [7:0]  pipeline_fps_limit_i,
  input  logic [7:0]  effective_fps_i,
  input  logic        bandwidth_limited_i,
  input  logic        loss_present_i,
  input  logic [13:0] loss_level_i,
  input  logic        rtt_present_i,
  input  logic [15:0] rtt_ms_i,
  input  logic [47:0] now_ms_i,
  input  logic        empty_i,
  input  logic        pop_i,
  input  logic [6:0]  fps_cap_i,
  input  logic        cap_changed_i,
  input  logic [1:0]  sample_kind_i,
  input  logic        load_high_i,
  output int          outstanding_o,
  output int          errors_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [6:0] fps_cap;
    logic       cap_changed;
    kind_e      kind;
    logic       load_high;
  } cap_word_t;

  logic        en_q;
  logic [7:0]  poor_lim;
  logic [7:0]  good_lim;
  logic [15:0] lower_hold;
  logic [15:0] raise_hold;
  logic [13:0] loss_lim;
  logic [15:0] rtt_lim;

  logic [63:0] last_idle;
  logic [63:0] last_total;
  logic [7:0]  poor_score;
  logic [7:0]  good_score;
  logic [6:0]  cap;
  logic [47:0] changed_at;

  cap_word_t   cap_q[$];
  cap_word_t   want;
  int          fault_count;

  task automatic report(string what);
    fault_count++;
    if (fault_count <= 100) $display("[%0t] ERROR: %s", $time, what);
  endtask

  // largest rung below the rate, floor of 10
  function automatic int lower_rung(int rate);
    int ladder [6];
    int r;
    ladder = '{15, 20, 30, 45, 60, 90};
    r = 10;
    foreach (ladder[i]) if (rate > ladder[i]) r = ladder[i];
    return r;
  endfunction

  // next rung above the cap limited to top; past 90 it is top, uncapped at top
  function automatic int higher_rung(int cur, int top);
    int ladder [6];
    int r;
    ladder = '{15, 20, 30, 45, 60, 90};
    if (cur == 0) return 0;
    r = (cur < top) ? top : 0;
    for (int i = 5; i >= 0; i--) begin
      if (cur < ladder[i]) r = (ladder[i] < top) ? ladder[i] : top;
    end
    return r;
  endfunction

  function automatic cap_word_t govern_sample();
    cap_word_t   w;
    logic [63:0] idle_step;
    logic [63:0] total_step;
    logic [63:0] busy;
    logic [66:0] busy_x5;
    logic [66:0] total_x2;
    logic        high;
    logic        comfy;
    logic        net_poor;
    logic        lowering;
    logic [15:0] hold;
    int          top;
    int          target;
    w.fps_cap     = cap;
    w.cap_changed = 1'b0;
    w.kind        = KIND_DISABLED;
    w.load_high   = 1'b0;
    if (!en_q) return w;
    if (last_total == '0 || total_ticks_i <= last_total || idle_ticks_i < last_idle) begin
      last_idle  = idle_ticks_i;
      last_total = total_ticks_i;
      w.kind     = KIND_BASELINE;
      return w;
    end
    idle_step  = idle_ticks_i - last_idle;
    total_step = total_ticks_i - last_total;
    last_idle  = idle_ticks_i;
    last_total = total_ticks_i;

    // idle running ahead of total counts as no busy time
    busy     = (idle_step < total_step) ? total_step - idle_step : '0;
    high     = busy >= total_step - busy;
    busy_x5  = {3'b000, busy} * 67'd5;
    total_x2 = {3'b000, total_step} * 67'd2;
    comfy    = busy_x5 < total_x2;

    if (pipeline_fps_limit_i == 8'd0) top = 1;
    else if (pipeline_fps_limit_i > {1'b0, MaxRate}) top = MaxRate;
    else top = pipeline_fps_limit_i;
    net_poor = bandwidth_limited_i || (loss_present_i && loss_level_i >= loss_lim) ||
               (rtt_present_i && rtt_ms_i >= rtt_lim);

    target = cap;
    if (high) begin
      if (poor_score != 8'hFF) poor_score++;
      good_score = '0;
      if (poor_score >= poor_lim) target = lower_rung(effective_fps_i);
    end else if (comfy && !net_poor) begin
      if (poor_score != 8'h00) poor_score--;
      if (good_score != 8'hFF) good_score++;
      if (good_score >= good_lim) target = higher_rung(cap, top);
    end else begin
      if (poor_score != 8'h00) poor_score--;
      if (good_score != 8'h00) good_score--;
    end
    if (target >= top) target = 0;

    if (target != cap) begin
      lowering = target > 0 && (cap == 0 || target < cap);
      hold = lowering ? lower_hold : raise_hold;
      // a zero change time means no change yet, so nothing holds it back
      if (changed_at == '0 || (now_ms_i >= changed_at && now_ms_i - changed_at >= hold)) begin
        cap           = 7'(target);
        changed_at    = now_ms_i;
        poor_score    = '0;
        good_score    = '0;
        w.cap_changed = 1'b1;
      end
    end
    w.fps_cap   = cap;
    w.kind      = KIND_EVAL;
    w.load_high = high;
    return w;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q        = 1'b1;
      poor_lim    = 8'd3;
      good_lim    = 8'd8;
      lower_hold  = 16'd5000;
      raise_hold  = 16'd15000;
      loss_lim    = 14'd300;
      rtt_lim     = 16'd350;
      last_idle   = '0;
      last_total  = '0;
      poor_score  = '0;
      good_score  = '0;
      cap         = '0;
      changed_at  = '0;
      fault_count = 0;
      cap_q.delete();
      outstanding_o <= 0;
      errors_o      <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_addr_i))
          CFG_ENABLE:     en_q       = cfg_wdata_i[0];
          CFG_POOR_LIMIT: poor_lim   = cfg_wdata_i[7:0];
          CFG_GOOD_LIMIT: good_lim   = cfg_wdata_i[7:0];
          CFG_LOWER_HOLD: lower_hold = cfg_wdata_i;
          CFG_RAISE_HOLD: raise_hold = cfg_wdata_i;
          CFG_LOSS_LIMIT: loss_lim   = cfg_wdata_i[13:0];
          CFG_RTT_LIMIT:  rtt_lim    = cfg_wdata_i;
          default: ;
        endcase
      end
      if (pop_i && !empty_i) begin
        if (cap_q.size() == 0) begin
          report("result word with nothing expected");
        end else begin
          want = cap_q.pop_front();
          if (fps_cap_i !== want.fps_cap)
            report($sformatf("fps_cap got %0d want %0d", fps_cap_i, want.fps_cap));
          if (cap_changed_i !== want.cap_changed)
            report($sformatf("cap_changed got %0b want %0b", cap_changed_i, want.cap_changed));
          if (sample_kind_i !== want.kind)
            report($sformatf("sample_kind got %0d want %0d", sample_kind_i, want.kind));
          if (load_high_i !== want.load_high)
            report($sformatf("load_high got %0b want %0b", load_high_i, want.load_high));
        end
      end
      if (push_i && !full_i) cap_q.push_back(govern_sample());
      outstanding_o <= cap_q.size();
      errors_o      <= fault_count;
    end
  end

endmodule

/* tb/load_adaptive_rate_governor_test.sv */
// ---------------------------------------------------------------------------
// load adaptive rate governor test
// drives directed samples through baseline, load, network and hold corners,
// then phases of random load sequences under several register settings with
// random gaps on both channels outside calm phases; the checker judges each word
// ---------------------------------------------------------------------------
module load_adaptive_rate_governor_test;
  timeunit 1ns;
  timeprecision 1ps;
  import larg_pkg::*;

  localparam int Limit = 400000;

  typedef struct {
    logic [63:0] idle;
    logic [63:0] total;
    logic [7:0]  pipe;
    logic [7:0]  eff;
    logic        bw;
    logic        loss_p;
    logic [13:0] loss;
    logic        rtt_p;
    logic [15:0] rtt;
    logic [47:0] now;
  } sample_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_addr_i = '0;
  logic [15:0] cfg_wdata_i = '0;
  logic        push_i = 1'b0;
  logic        full_o;
  logic [63:0] idle_ticks_i = '0;
  logic [63:0] total_ticks_i = '0;
  logic [7:0]  pipeline_fps_limit_i = '0;
  logic [7:0]  effective_fps_i = '0;
  logic        bandwidth_limited_i = 1'b0;
  logic        loss_present_i = 1'b0;
  logic [13:0] loss_level_i = '0;
  logic        rtt_present_i = 1'b0;
  logic [15:0] rtt_ms_i = '0;
  logic [47:0] now_ms_i = '0;
  logic        empty_o;
  logic        pop_i = 1'b0;
  logic [6:0]  fps_cap_o;
  logic        cap_changed_o;
  logic [1:0]  sample_kind_o;
  logic        load_high_o;

  int          outstanding;
  int          errors;
  int          cycles = 0;
  bit          calm = 1'b0;
  sample_t     shape;
  logic [63:0] idle_acc;
  logic [63:0] total_acc;
  logic [47:0] clock_ms;

  load_adaptive_rate_governor DUT (.*);

  load_adaptive_rate_governor_checker u_cap_check (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_addr_i, .cfg_wdata_i,
    .push_i, .full_i(full_o),
    .idle_ticks_i, .total_ticks_i, .pipeline_fps_limit_i, .effective_fps_i,
    .bandwidth_limited_i, .loss_present_i, .loss_level_i, .rtt_present_i, .rtt_ms_i,
    .now_ms_i, .empty_i(empty_o), .pop_i,
    .fps_cap_i(fps_cap_o), .cap_changed_i(cap_changed_o),
    .sample_kind_i(sample_kind_o), .load_high_i(load_high_o),
    .outstanding_o(outstanding), .errors_o(errors)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > Limit) begin
      $display("load_adaptive_rate_governor: mismatch");
      $finish;
    end
  end

  function automatic logic [63:0] upto(logic [63:0] hi);
    logic [63:0] r;
    r = {$urandom, $urandom};
    return (hi == '1) ? r : r % (hi + 64'd1);
  endfunction

  task automatic push_sample(sample_t s);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      push_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push_i               <= 1'b1;
    idle_ticks_i         <= s.idle;
    total_ticks_i        <= s.total;
    pipeline_fps_limit_i <= s.pipe;
    effective_fps_i      <= s.eff;
    bandwidth_limited_i  <= s.bw;
    loss_present_i       <= s.loss_p;
    loss_level_i         <= s.loss;
    rtt_present_i        <= s.rtt_p;
    rtt_ms_i             <= s.rtt;
    now_ms_i             <= s.now;
    @(posedge clk_i);
    while (full_o) @(posedge clk_i);
  endtask

  // advance the running counters and send a word with the current shape
  task automatic send_delta(logic [63:0] id, logic [63:0] td);
    idle_acc    += id;
    total_acc   += td;
    shape.idle  = idle_acc;
    shape.total = total_acc;
    push_sample(shape);
  endtask

  task automatic drain();
    push_i <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [15:0] value);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_regs(logic en, logic [7:0] poor, logic [7:0] good, logic [15:0] lower,
                          logic [15:0] raise, logic [13:0] loss, logic [15:0] rtt);
    write_reg(CFG_ENABLE, {15'd0, en});
    write_reg(CFG_POOR_LIMIT, {8'd0, poor});
    write_reg(CFG_GOOD_LIMIT, {8'd0, good});
    write_reg(CFG_LOWER_HOLD, lower);
    write_reg(CFG_RAISE_HOLD, raise);
    write_reg(CFG_LOSS_LIMIT, {2'd0, loss});
    write_reg(CFG_RTT_LIMIT, rtt);
  endtask

  // segments of high, comfortable or middling load, with some broken counters
  task automatic run_phase(int count);
    int          regime;
    int          seg_left;
    logic [63:0] td;
    logic [63:0] busy;
    logic [63:0] lo;
    logic [63:0] hi;
    seg_left = 0;
    regime = 0;
    for (int n = 0; n < count; n++) begin
      if (seg_left == 0) begin
        regime   = ($urandom_range(0, 7) == 0) ? 3 : $urandom_range(0, 2);
        seg_left = $urandom_range(1, 16);
        case ($urandom_range(0, 9))
          0: shape.pipe = 8'd0;
          1: shape.pipe = 8'd1;
          2: shape.pipe = 8'hFF;
          3: shape.pipe = {1'b0, MaxRate};
          4: shape.pipe = {1'b0, MaxRate} + 8'd1;
          5: shape.pipe = $urandom_range(10, 90);
          default: shape.pipe = $urandom_range(0, 255);
        endcase
      end
      seg_left--;
      shape.eff = $urandom_range(0, 255);
      if ($urandom_range(0, 9) < 7) begin
        shape.bw     = 1'b0;
        shape.loss_p = 1'b0;
        shape.rtt_p  = 1'b0;
      end else begin
        shape.bw     = ($urandom_range(0, 3) == 0);
        shape.loss_p = $urandom_range(0, 1);
        shape.rtt_p  = $urandom_range(0, 1);
      end
      shape.loss = $urandom_range(0, 1) ? $urandom_range(0, 10000) : $urandom_range(0, 400);
      shape.rtt  = $urandom_range(0, 1) ? $urandom_range(0, 65535) : $urandom_range(0, 500);
      case ($urandom_range(0, 19))
        0: clock_ms = {$urandom, $urandom};
        1: clock_ms -= $urandom_range(0, 20000);
        default: clock_ms += $urandom_range(0, 6000);
      endcase
      shape.now = clock_ms;

      if ($urandom_range(0, 7) == 0) td = {$urandom, $urandom} >> $urandom_range(2, 63);
      else td = $urandom_range(1, 100000);
      if (td == '0) td = 64'd1;

      case (regime)
        0: begin
          lo   = (td + 64'd1) >> 1;
          busy = lo + upto(td - lo);
          send_delta(td - busy, td);
        end
        1: begin
          busy = upto((td * 2 - 64'd1) / 5);
          send_delta(td - busy, td);
        end
        2: begin
          lo = (td * 2 + 64'd4) / 5;
          hi = (td - 64'd1) >> 1;
          busy = (lo > hi) ? td : lo + upto(hi - lo);
          send_delta(td - busy, td);
        end
        default: begin
          case ($urandom_range(0, 4))
            0: begin
              idle_acc  = {$urandom, $urandom};
              total_acc = {$urandom, $urandom};
              send_delta('0, '0);
            end
            1: send_delta('0, '0);
            2: begin
              idle_acc -= 64'd1 + $urandom_range(0, 1000);
              send_delta('0, td);
            end
            3: send_delta(td + $urandom_range(1, 1000), td);
            default: begin
              idle_acc  = '0;
              total_acc = '0;
              send_delta('0, '0);
            end
          endcase
        end
      endcase
    end
  endtask

  initial begin
    int wait_n;
    @(posedge rst_ni);
    forever begin
      wait_n = calm ? 0 : $urandom_range(0, 9);
      if (wait_n != 0) begin
        pop_i <= 1'b0;
        repeat (wait_n) @(posedge clk_i);
      end
      pop_i <= 1'b1;
      @(posedge clk_i);
      while (empty_o) @(posedge clk_i);
    end
  end

  initial begin
    shape.pipe   = {1'b0, MaxRate};
    shape.eff    = 8'd60;
    shape.bw     = 1'b0;
    shape.loss_p = 1'b0;
    shape.loss   = '0;
    shape.rtt_p  = 1'b0;
    shape.rtt    = '0;
    shape.now    = '0;
    idle_acc     = '0;
    total_acc    = '0;
    clock_ms     = 48'd100000;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // baseline reloads: zero counters, first sample, total unchanged, idle backwards
    send_delta('0, '0);
    idle_acc  = 64'd100;
    total_acc = 64'd1000;
    send_delta('0, '0);
    send_delta('0, '0);
    idle_acc  = 64'd50;
    total_acc = 64'd2000;
    send_delta('0, '0);
    // idle delta above total delta
    send_delta(64'd1000, 64'd500);
    // load boundaries with the top rate at its floor
    shape.pipe = 8'd0;
    shape.eff  = 8'hFF;
    send_delta(64'd500, 64'd1000);
    send_delta(64'd600, 64'd1000);
    // first change at time zero, then one with no hold, then time going backwards
    shape.pipe = 8'hFF;
    repeat (3) send_delta('0, 64'd1000);
    shape.eff = 8'd20;
    shape.now = 48'd50000;
    repeat (3) send_delta('0, 64'd1000);
    shape.eff = 8'd0;
    shape.now = 48'd10;
    repeat (3) send_delta('0, 64'd1000);
    // network poor exactly at the limits, then loss 10000, rtt at its field maximum
    shape.now    = '1;
    shape.bw     = 1'b1;
    shape.loss_p = 1'b1;
    shape.loss   = 14'd300;
    shape.rtt_p  = 1'b1;
    shape.rtt    = 16'd350;
    send_delta(64'd1000, 64'd1000);
    shape.bw   = 1'b0;
    shape.loss = 14'd10000;
    shape.rtt  = '1;
    send_delta(64'd1000, 64'd1000);
    // counters near the top of their range
    shape.loss_p = 1'b0;
    shape.rtt_p  = 1'b0;
    shape.pipe   = 8'd1;
    idle_acc     = 64'h7FFF_FFFF_FFFF_FFFF;
    total_acc    = 64'hFFFF_FFFF_FFFF_FFFE;
    send_delta('0, '0);
    send_delta(64'h8000_0000_0000_0000, 64'd1);

    drain();
    set_regs(1'b0, 8'd3, 8'd8, 16'd5000, 16'd15000, 14'd300, 16'd350);
    run_phase(20);
    drain();
    set_regs(1'b1, 8'd1, 8'd1, 16'd0, 16'd0, 14'd0, 16'd0);
    run_phase(180);
    calm = 1'b1;
    drain();
    set_regs(1'b1, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 14'd10000, 16'hFFFF);
    run_phase(180);
    calm = 1'b0;
    drain();
    set_regs(1'b1, 8'd0, 8'd0, 16'd1000, 16'd3000, 14'd300, 16'd350);
    run_phase(180);
    drain();
    set_regs(1'b1, 8'd2, 8'd3, 16'd2000, 16'd4000, 14'h3FFF, 16'd200);
    run_phase(180);
    calm = 1'b1;
    drain();
    set_regs(1'b1, $urandom_range(1, 8), $urandom_range(1, 12), $urandom_range(0, 8000),
             $urandom_range(0, 16000), $urandom_range(0, 10000), $urandom_range(0, 65535));
    run_phase(180);
    calm = 1'b0;
    drain();
    set_regs(1'b1, 8'd3, 8'd8, 16'd5000, 16'd15000, 14'd300, 16'd350);
    run_phase(180);
    drain();
    set_regs(1'b1, $urandom_range(0, 255), $urandom_range(0, 10), $urandom_range(0, 65535),
             $urandom_range(0, 65535), $urandom_range(0, 16383), $urandom_range(0, 65535));
    run_phase(180);

    drain();
    repeat (8) @(posedge clk_i);
    if (errors == 0) begin
      $display("load_adaptive_rate_governor: match");
    end else begin
      $display("load_adaptive_rate_governor: mismatch");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+sv
sv/larg_pkg.sv
sv/larg_front.sv
sv/larg_queue.sv
sv/larg_back.sv
sv/load_adaptive_rate_governor.sv
sv/larg_checker.sv
tb/load_adaptive_rate_governor_checker.sv
tb/load_adaptive_rate_governor_test.sv
